@@ rtl/pal_pkg.sv @@
// Shared types and codes for the packet acknowledgement ring log.
package pal_pkg;

  // Request command codes.
  localparam logic [2:0] CMD_SENT     = 3'd0;
  localparam logic [2:0] CMD_RECEIVED = 3'd1;
  localparam logic [2:0] CMD_RESENT   = 3'd2;
  localparam logic [2:0] CMD_ACKED    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  // Record state codes.
  localparam logic [2:0] ST_EMPTY    = 3'd0;
  localparam logic [2:0] ST_SENT     = 3'd1;
  localparam logic [2:0] ST_RECEIVED = 3'd2;
  localparam logic [2:0] ST_RESENT   = 3'd3;
  localparam logic [2:0] ST_ACKED    = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] sequence_req;
    logic [15:0] packet_size;
    logic [5:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic        match_found;
    logic [15:0] entry_sequence;
    logic [2:0]  entry_state;
    logic        entry_outbound;
    logic [15:0] entry_size;
    logic [6:0]  line_start;
    logic [5:0]  write_position;
  } out_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [2:0]  state;
    logic        outbound;
    logic [15:0] size;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture the request, restart the counters
    logic zero_step;   // write an empty record at the sweep address
    logic log_write;   // write the logged record and advance the write position
    logic scan_issue;  // read the next slot of the scan
    logic scan_check;  // compare the slot read last cycle and mark it on a match
    logic read_issue;  // read the requested slot
    logic respond;     // load the result register
  } pal_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last_depth;  // sweep counter is on the last slot of the ring
    logic last_line;   // sweep counter is on the last slot of a line clear
    logic line_wrap;   // the write position about to be taken lands on a line boundary
    logic hit;         // the scanned slot is outbound and its sequence matches
  } pal_stat_t;

endpackage

@@ rtl/pal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pal_ctrl.sv @@
// Controller state machine of the packet acknowledgement ring log.
module pal_ctrl
  import pal_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [2:0] cmd_code,
  input  pal_stat_t stat,
  output logic      busy,
  output pal_cmd_t  ctl
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LOG   = 8'b0000_0100,
    S_CLEAR = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_TAIL  = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } pal_state_t;

  pal_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    unique case (state)
      S_INIT: begin
        ctl.zero_step = 1'b1;
        if (stat.last_depth) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          priority if (cmd_code == CMD_SENT || cmd_code == CMD_RECEIVED) begin
            state_next = S_LOG;
          end else if (cmd_code == CMD_RESENT || cmd_code == CMD_ACKED) begin
            state_next = S_SCAN;
          end else if (cmd_code == CMD_READ) begin
            state_next = S_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_LOG: begin
        ctl.log_write = 1'b1;
        state_next    = stat.line_wrap ? S_CLEAR : S_DONE;
      end
      S_CLEAR: begin
        ctl.zero_step = 1'b1;
        if (stat.last_line) begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.scan_issue = 1'b1;
        ctl.scan_check = 1'b1;
        if (stat.hit) begin
          state_next = S_DONE;
        end else if (stat.last_depth) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        // The last slot's data arrives in the cycle after its read.
        ctl.scan_check = 1'b1;
        state_next     = S_DONE;
      end
      S_RD: begin
        ctl.read_issue = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        ctl.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.hit |-> (state == S_SCAN || state == S_TAIL))
    else $error("match reported outside a scan");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state != S_IDLE))
    else $error("accepted request did not start work");

  a_busy_falls: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(ctl.respond) || $past(state == S_INIT)))
    else $error("busy dropped without a response or end of initial clear");

endmodule

@@ rtl/pal_dp.sv @@
// Datapath of the packet acknowledgement ring log: record memory, pointers, result register.
module pal_dp
  import pal_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int LINE_LENGTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  pal_cmd_t  ctl,
  input  in_t       request,
  output pal_stat_t stat,
  output logic      done,
  output out_t      result
);

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW        = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
  localparam int CLEAR_LEN = (LINE_LENGTH < DEPTH) ? LINE_LENGTH : DEPTH;
  localparam int LINE_MOD  = LINE_LENGTH % DEPTH;

  localparam logic [AW-1:0] LAST_SLOT     = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LAST_CLEAR    = AW'(CLEAR_LEN - 1);
  localparam logic [LW-1:0] LAST_LINE_POS = LW'(LINE_LENGTH - 1);
  localparam logic [AW:0]   DEPTH_W       = (AW + 1)'(DEPTH);
  localparam logic [AW:0]   LINE_MOD_W    = (AW + 1)'(LINE_MOD);
  localparam logic [6:0]    LS_RESET      = 7'(LINE_LENGTH);

  in_t           req_q;
  logic [AW-1:0] next_slot;
  logic [LW-1:0] line_pos;
  logic [6:0]    line_start;
  logic [AW-1:0] addr;
  logic [AW-1:0] cnt;
  logic [AW-1:0] rd_addr;
  logic          rd_valid;
  logic          match_q;

  logic [AW-1:0]    ns_inc;
  logic [AW-1:0]    addr_inc;
  logic [AW:0]      ls_sum;
  logic [AW:0]      ls_mod;
  logic             line_wrap;
  logic             hit;
  logic             slot_ok;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [REC_W-1:0] wdata;
  logic [REC_W-1:0] rdata;
  record_t          rd_rec;
  record_t          log_rec;
  record_t          mark_rec;

  pal_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_rec   = record_t'(rdata);
  assign ns_inc   = (next_slot == LAST_SLOT) ? '0 : next_slot + 1'b1;
  assign addr_inc = (addr == LAST_SLOT) ? '0 : addr + 1'b1;

  // The advanced position is a line boundary when the ring wraps or the line fills.
  assign line_wrap = (next_slot == LAST_SLOT) || (line_pos == LAST_LINE_POS);
  assign ls_sum    = {1'b0, ns_inc} + LINE_MOD_W;
  assign ls_mod    = (ls_sum >= DEPTH_W) ? ls_sum - DEPTH_W : ls_sum;

  assign hit = ctl.scan_check && rd_valid && rd_rec.outbound &&
               (rd_rec.seq == req_q.sequence_req);

  assign slot_ok = 32'(req_q.slot_index) < 32'(DEPTH);

  always_comb begin
    log_rec.seq      = req_q.sequence_req;
    log_rec.state    = (req_q.cmd == CMD_SENT) ? ST_SENT : ST_RECEIVED;
    log_rec.outbound = (req_q.cmd == CMD_SENT);
    log_rec.size     = req_q.packet_size;
    mark_rec         = rd_rec;
    mark_rec.state   = (req_q.cmd == CMD_RESENT) ? ST_RESENT : ST_ACKED;
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    priority if (ctl.zero_step) begin
      we = 1'b1;
    end else if (ctl.log_write) begin
      we    = 1'b1;
      waddr = next_slot;
      wdata = log_rec;
    end else if (hit) begin
      we    = 1'b1;
      waddr = rd_addr;
      wdata = mark_rec;
    end
  end

  assign raddr = ctl.scan_issue ? addr : AW'(req_q.slot_index);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= request;
    end
    if (ctl.scan_issue) begin
      rd_addr <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot  <= '0;
      line_pos   <= '0;
      line_start <= LS_RESET;
      addr       <= '0;
      cnt        <= '0;
      rd_valid   <= 1'b0;
      match_q    <= 1'b0;
    end else begin
      rd_valid <= ctl.scan_issue;
      if (ctl.load) begin
        addr    <= '0;
        cnt     <= '0;
        match_q <= 1'b0;
      end
      if (ctl.zero_step || ctl.scan_issue) begin
        addr <= addr_inc;
        cnt  <= cnt + 1'b1;
      end
      if (ctl.log_write) begin
        next_slot <= ns_inc;
        line_pos  <= line_wrap ? '0 : line_pos + 1'b1;
        addr      <= ns_inc;
        cnt       <= '0;
        if (line_wrap) begin
          line_start <= 7'(ls_mod[AW-1:0]);
        end
      end
      if (hit) begin
        match_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      result.match_found    <= match_q;
      result.line_start     <= line_start;
      result.write_position <= 6'(next_slot);
      if (req_q.cmd == CMD_READ && slot_ok) begin
        result.entry_sequence <= rd_rec.seq;
        result.entry_state    <= rd_rec.state;
        result.entry_outbound <= rd_rec.outbound;
        result.entry_size     <= rd_rec.size;
      end else begin
        result.entry_sequence <= '0;
        result.entry_state    <= ST_EMPTY;
        result.entry_outbound <= 1'b0;
        result.entry_size     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.respond;
    end
  end

  assign stat.last_depth = (cnt == LAST_SLOT);
  assign stat.last_line  = (cnt == LAST_CLEAR);
  assign stat.line_wrap  = line_wrap;
  assign stat.hit        = hit;

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.zero_step, ctl.log_write, hit}))
    else $error("more than one source writes the record memory");

  a_line_aligned_at_zero: assert property (@(posedge clk) disable iff (rst)
    (next_slot == '0) |-> (line_pos == '0))
    else $error("line position out of step with write position");

  a_log_advances: assert property (@(posedge clk) disable iff (rst)
    ctl.log_write |=> (next_slot != $past(next_slot)))
    else $error("logging did not advance the write position");

endmodule

@@ rtl/packet_ack_ring_log.sv @@
// Top level of the packet acknowledgement ring log.
//
// A ring of DEPTH packet records held in one RAM. A request is taken when start is high
// and busy is low; its single result appears on result for one cycle with done high, and
// must be taken then. After reset the block sweeps every RAM slot to empty with busy
// high. A sent or received request writes its record at the write position; when the
// advanced position reaches a line boundary, the next min(LINE_LENGTH, DEPTH) slots are
// cleared one slot per cycle. A resent or acked request scans from slot 0, one RAM read
// per cycle, and stops at the first outbound match or after the last slot. A read request
// reads one slot, and codes 5 to 7 go straight to the result. The RAM's single write
// and read ports pace the clear and the scan. busy goes low in the cycle that done is high.
module packet_ack_ring_log
  import pal_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int LINE_LENGTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic done,
  output out_t result
);

  pal_cmd_t  ctl;
  pal_stat_t stat;

  pal_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd_code(request.cmd),
    .stat    (stat),
    .busy    (busy),
    .ctl     (ctl)
  );

  pal_dp #(
    .DEPTH      (DEPTH),
    .LINE_LENGTH(LINE_LENGTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .request(request),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the packet acknowledgement ring log.
`timescale 1ns / 1ps

module testbench;
  import pal_pkg::*;

  localparam int DEPTH       = 64;
  localparam int LINE_LENGTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = DEPTH + LINE_LENGTH + 8;
  localparam int RANDOM_REQUESTS = 700;

  // Command codes the block leaves unused.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  request;
  logic done;
  out_t result;

  packet_ack_ring_log #(
    .DEPTH      (DEPTH),
    .LINE_LENGTH(LINE_LENGTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // Predicted contents of the ring.
  record_t     ring_model [DEPTH];
  logic [5:0]  model_write_pos;
  logic [6:0]  model_line_start;

  out_t        pending_results[$];
  logic [15:0] sent_history[$];
  int          mismatch_count;
  int          cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Print only the first hundred mismatches but count them all.
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("match_found", 16'(result.match_found), 16'(want.match_found));
        check_field("entry_sequence", result.entry_sequence, want.entry_sequence);
        check_field("entry_state", 16'(result.entry_state), 16'(want.entry_state));
        check_field("entry_outbound", 16'(result.entry_outbound),
                    16'(want.entry_outbound));
        check_field("entry_size", result.entry_size, want.entry_size);
        check_field("line_start", 16'(result.line_start), 16'(want.line_start));
        check_field("write_position", 16'(result.write_position),
                    16'(want.write_position));
      end
    end
  end

  function automatic void clear_ring_model();
    for (int i = 0; i < DEPTH; i++) begin
      ring_model[i] = '0;
    end
    model_write_pos  = '0;
    model_line_start = 7'(LINE_LENGTH);
  endfunction

  // Write the next slot; on reaching a line boundary, empty the following line.
  function automatic void log_packet_event(logic [15:0] seq, logic [2:0] state,
                                           logic outbound, logic [15:0] size);
    int pos;
    pos = int'(model_write_pos);
    ring_model[pos].seq      = seq;
    ring_model[pos].state    = state;
    ring_model[pos].outbound = outbound;
    ring_model[pos].size     = size;
    pos = (pos + 1) % DEPTH;
    model_write_pos = 6'(pos);
    if (pos % LINE_LENGTH == 0) begin
      model_line_start = 7'((pos + LINE_LENGTH) % DEPTH);
      for (int i = 0; i < LINE_LENGTH; i++) begin
        ring_model[(pos + i) % DEPTH] = '0;
      end
    end
  endfunction

  // The scan always starts at slot 0, so the lowest matching slot wins.
  function automatic logic mark_first_outbound(logic [15:0] seq, logic [2:0] state);
    for (int i = 0; i < DEPTH; i++) begin
      if (ring_model[i].outbound && ring_model[i].seq == seq) begin
        ring_model[i].state = state;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_t predict_result(in_t req);
    out_t r;
    r = '0;
    case (req.cmd)
      CMD_SENT: begin
        log_packet_event(req.sequence_req, ST_SENT, 1'b1, req.packet_size);
      end
      CMD_RECEIVED: begin
        log_packet_event(req.sequence_req, ST_RECEIVED, 1'b0, req.packet_size);
      end
      CMD_RESENT: begin
        r.match_found = mark_first_outbound(req.sequence_req, ST_RESENT);
      end
      CMD_ACKED: begin
        r.match_found = mark_first_outbound(req.sequence_req, ST_ACKED);
      end
      CMD_READ: begin
        if (req.slot_index < DEPTH) begin
          r.entry_sequence = ring_model[req.slot_index].seq;
          r.entry_state    = ring_model[req.slot_index].state;
          r.entry_outbound = ring_model[req.slot_index].outbound;
          r.entry_size     = ring_model[req.slot_index].size;
        end
      end
      default: begin
      end
    endcase
    r.line_start     = model_line_start;
    r.write_position = model_write_pos;
    return r;
  endfunction

  function automatic in_t make_request(logic [2:0] cmd, logic [15:0] seq,
                                       logic [15:0] size, logic [5:0] slot);
    in_t req;
    req.cmd          = cmd;
    req.sequence_req = seq;
    req.packet_size  = size;
    req.slot_index   = slot;
    return req;
  endfunction

  // start stays high after acceptance so back-to-back requests need no toggle.
  task automatic send_request(in_t req, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_result(req));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_reset_state();
    send_request(make_request(CMD_READ, 16'hFFFF, 16'hFFFF, 6'd0), 0);
    send_request(make_request(CMD_READ, 16'h0000, 16'h0000, 6'd63), 0);
  endtask

  task automatic test_logging_and_scans();
    send_request(make_request(CMD_SENT, 16'h0000, 16'h0000, 6'd63), 0);
    send_request(make_request(CMD_SENT, 16'hFFFF, 16'hFFFF, 6'd0), 1);
    send_request(make_request(CMD_RECEIVED, 16'h1234, 16'h8000, 6'd21), 0);
    send_request(make_request(CMD_SENT, 16'h00A5, 16'h5A5A, 6'd42), 2);
    send_request(make_request(CMD_SENT, 16'h00A5, 16'h0001, 6'd0), 0);
    // Duplicate sequence: both scans must land on the lower slot.
    send_request(make_request(CMD_RESENT, 16'h00A5, 16'h0000, 6'd0), 0);
    send_request(make_request(CMD_ACKED, 16'h00A5, 16'hFFFF, 6'd63), 3);
    // A received packet is not outbound, so the scan misses.
    send_request(make_request(CMD_ACKED, 16'h1234, 16'h0000, 6'd0), 0);
    send_request(make_request(CMD_RESENT, 16'h7777, 16'h0000, 6'd0), 0);
    send_request(make_request(CMD_ACKED, 16'hFFFF, 16'h0000, 6'd0), 0);
    for (int s = 0; s < 5; s++) begin
      send_request(make_request(CMD_READ, 16'hAAAA, 16'h5555, 6'(s)), s % 2);
    end
  endtask

  task automatic test_unused_commands();
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
      send_request(make_request(3'(c), 16'hFFFF, 16'hFFFF, 6'd63), 0);
    end
  endtask

  task automatic test_drain_pause();
    send_request(make_request(CMD_SENT, 16'h0042, 16'h0100, 6'd0), 0);
    send_request(make_request(CMD_READ, 16'h0000, 16'h0000, model_write_pos - 6'd1), 0);
    wait_for_results();
    send_request(make_request(CMD_RESENT, 16'h0042, 16'h0000, 6'd0), 0);
  endtask

  // Mostly well-formed traffic: small sequence pool so scans hit, reads anywhere.
  function automatic in_t random_event();
    int   pick;
    logic [15:0] seq;
    logic [15:0] size;
    logic [2:0]  cmd;
    pick = $urandom_range(0, 99);
    seq  = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    case ($urandom_range(0, 5))
      0: size = 16'h0000;
      1: size = 16'hFFFF;
      default: size = 16'($urandom);
    endcase
    if (pick < 35) begin
      cmd = CMD_SENT;
      sent_history.push_back(seq);
      if (sent_history.size() > 16) begin
        void'(sent_history.pop_front());
      end
    end else if (pick < 50) begin
      cmd = CMD_RECEIVED;
    end else if (pick < 80) begin
      cmd = (pick < 65) ? CMD_RESENT : CMD_ACKED;
      if (sent_history.size() > 0 && $urandom_range(0, 9) < 7) begin
        seq = sent_history[$urandom_range(0, sent_history.size() - 1)];
      end
    end else if (pick < 96) begin
      cmd = CMD_READ;
    end else begin
      cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return make_request(cmd, seq, size, 6'($urandom));
  endfunction

  task automatic test_random_traffic(int count);
    bit calm;
    calm = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      if (n % 150 == 149) begin
        wait_for_results();
      end
      send_request(random_event(), calm ? 0 : $urandom_range(0, 6));
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    mismatch_count = 0;
    clear_ring_model();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_logging_and_scans();
    test_unused_commands();
    test_drain_pause();
    test_random_traffic(RANDOM_REQUESTS);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
